// ===== rtl/qsn_pkg.sv =====
// Shared constants and types of the quadric surface normal unit.
`default_nettype none
package qsn_pkg;
	localparam int COORD_WIDTH_DEF  = 32;
	localparam int NORMAL_WIDTH_DEF = 16;
	localparam int FRAC_BITS        = 16;
	localparam int NORM_BITS        = 30;
	localparam int SUM_WIDTH        = 2 * NORM_BITS + 2;
	localparam int ROOT_WIDTH       = NORM_BITS + 1;

	typedef enum logic [1:0] {
		OP_SPHERE   = 2'd0,
		OP_CYLINDER = 2'd1,
		OP_CONE     = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	// Travels with every item down the pipe.
	typedef struct packed {
		logic       valid;
		logic [2:0] neg;
	} tag_t;
endpackage
`default_nettype wire

// ===== rtl/qsn_if.sv =====
// Handshake channels of the quadric surface normal unit.
`default_nettype none
interface qsn_in_if #(parameter int CW = 32);
	logic                 valid;
	logic                 ready;
	logic [1:0]           op;
	logic signed [CW-1:0] center_x;
	logic signed [CW-1:0] center_y;
	logic signed [CW-1:0] center_z;
	logic signed [CW-1:0] cone_slope;
	logic signed [CW-1:0] point_x;
	logic signed [CW-1:0] point_y;
	logic signed [CW-1:0] point_z;

	modport source (output valid, op, center_x, center_y, center_z, cone_slope,
		point_x, point_y, point_z, input ready);
	modport sink (input valid, op, center_x, center_y, center_z, cone_slope,
		point_x, point_y, point_z, output ready);
endinterface

interface qsn_out_if #(parameter int NW = 16);
	logic                 valid;
	logic                 ready;
	logic signed [NW-1:0] normal_x;
	logic signed [NW-1:0] normal_y;
	logic signed [NW-1:0] normal_z;
	logic                 degenerate;

	modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface
`default_nettype wire

// ===== rtl/quadric_surface_normal.sv =====
// Top level of the quadric surface normal unit.
// Turns a hit point on a sphere, a z-axis cylinder or a z-axis cone (Q16.16 inputs) into a
// unit normal in Q1.15, saturated at the largest positive code. One item is accepted every
// cycle while the result side keeps up. The pipe holds seven front stages (differences,
// cone product, range reduction, squares, sum), 31 square-root stages (one root bit each),
// one dividend stage, NORMAL_WIDTH divider stages and one output stage. The whole pipe
// stalls as one when a held result is not taken, so ready follows the output side. A
// zero-length vector or the kind "none" gives a zero normal with degenerate set.
`default_nettype none
module quadric_surface_normal #(
	parameter int COORD_WIDTH  = qsn_pkg::COORD_WIDTH_DEF,
	parameter int NORMAL_WIDTH = qsn_pkg::NORMAL_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	qsn_in_if.sink      req,
	qsn_out_if.source   rsp
);
	import qsn_pkg::*;

	logic adv;

	// advance whenever the output register is empty or being taken
	assign adv       = !rsp.valid || rsp.ready;
	// hold off the sender while reset holds the pipe
	assign req.ready = adv && arst_n;

	tag_t               f_tag;
	logic [2:0][NORM_BITS-1:0] f_mag;
	logic [SUM_WIDTH-1:0]      f_sum;

	qsn_front #(.CW(COORD_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (req.valid),
		.op         (req.op),
		.center_x   (req.center_x),
		.center_y   (req.center_y),
		.center_z   (req.center_z),
		.cone_slope (req.cone_slope),
		.point_x    (req.point_x),
		.point_y    (req.point_y),
		.point_z    (req.point_z),
		.out_tag    (f_tag),
		.out_mag    (f_mag),
		.out_sum    (f_sum)
	);

	tag_t                      r_tag;
	logic [2:0][NORM_BITS-1:0] r_mag;
	logic [ROOT_WIDTH-1:0]     r_root;

	qsn_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_tag   (f_tag),
		.in_mag   (f_mag),
		.in_sum   (f_sum),
		.out_tag  (r_tag),
		.out_mag  (r_mag),
		.out_root (r_root)
	);

	qsn_div #(.NW(NORMAL_WIDTH)) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_tag     (r_tag),
		.in_mag     (r_mag),
		.in_root    (r_root),
		.out_valid  (rsp.valid),
		.normal_x   (rsp.normal_x),
		.normal_y   (rsp.normal_y),
		.normal_z   (rsp.normal_z),
		.degenerate (rsp.degenerate)
	);
endmodule
`default_nettype wire

// ===== rtl/qsn_front.sv =====
// Front stages: differences, cone product, range reduction and sum of squares.
`default_nettype none
module qsn_front #(
	parameter int CW = qsn_pkg::COORD_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  adv,
	input  logic                                  in_valid,
	input  logic [1:0]                            op,
	input  logic signed [CW-1:0]                  center_x,
	input  logic signed [CW-1:0]                  center_y,
	input  logic signed [CW-1:0]                  center_z,
	input  logic signed [CW-1:0]                  cone_slope,
	input  logic signed [CW-1:0]                  point_x,
	input  logic signed [CW-1:0]                  point_y,
	input  logic signed [CW-1:0]                  point_z,
	output qsn_pkg::tag_t                         out_tag,
	output logic [2:0][qsn_pkg::NORM_BITS-1:0]    out_mag,
	output logic [qsn_pkg::SUM_WIDTH-1:0]         out_sum
);
	import qsn_pkg::*;

	localparam int DW = CW + 1;
	localparam int MW = 2 * CW + 1 - FRAC_BITS;
	localparam int LW = $clog2(MW + 1);
	localparam int NB = NORM_BITS;

	// stage 1: differences
	logic                 v_s1;
	op_t                  op_s1;
	logic signed [DW-1:0] d_s1 [3];
	logic signed [CW-1:0] slope_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1    <= op_t'(op);
			d_s1[0]  <= DW'(point_x) - DW'(center_x);
			d_s1[1]  <= DW'(point_y) - DW'(center_y);
			d_s1[2]  <= DW'(point_z) - DW'(center_z);
			slope_s1 <= cone_slope;
		end
	end

	// stage 2: magnitudes and signs
	logic          v_s2;
	op_t           op_s2;
	logic [DW-1:0] dm_s2 [3];
	logic [2:0]    dneg_s2;
	logic [CW-1:0] sm_s2;
	logic          sneg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2 <= op_s1;
			for (int i = 0; i < 3; i++) begin
				dm_s2[i]   <= d_s1[i][DW-1] ? DW'(-d_s1[i]) : DW'(d_s1[i]);
				dneg_s2[i] <= d_s1[i][DW-1];
			end
			sm_s2   <= slope_s1[CW-1] ? CW'(-slope_s1) : CW'(slope_s1);
			sneg_s2 <= slope_s1[CW-1];
		end
	end

	// stage 3: cone product and kind select
	logic [2*CW:0] prod;
	logic [MW-1:0] zc;
	logic          zc_neg;
	logic [MW-1:0] m_nx [3];
	logic [2:0]    neg_nx;

	assign prod   = (2*CW+1)'(sm_s2) * (2*CW+1)'(dm_s2[2]);
	assign zc     = prod[2*CW:FRAC_BITS];
	assign zc_neg = (sneg_s2 == dneg_s2[2]) && (zc != '0);

	always_comb begin
		m_nx[0] = MW'(dm_s2[0]);
		m_nx[1] = MW'(dm_s2[1]);
		neg_nx  = dneg_s2;
		case (op_s2)
			OP_SPHERE: begin
				m_nx[2] = MW'(dm_s2[2]);
			end
			OP_CYLINDER: begin
				m_nx[2]   = '0;
				neg_nx[2] = 1'b0;
			end
			OP_CONE: begin
				m_nx[2]   = zc;
				neg_nx[2] = zc_neg;
			end
			OP_NONE: begin
				m_nx[0] = '0;
				m_nx[1] = '0;
				m_nx[2] = '0;
				neg_nx  = '0;
			end
			default: begin
				m_nx[2] = '0;
				neg_nx  = '0;
			end
		endcase
	end

	logic          v_s3;
	logic [MW-1:0] m_s3 [3];
	logic [2:0]    neg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s3   <= m_nx;
			neg_s3 <= neg_nx;
		end
	end

	// stage 4: bit length of the largest magnitude
	logic [MW-1:0] orv;
	logic [LW-1:0] len;

	assign orv = m_s3[0] | m_s3[1] | m_s3[2];

	always_comb begin
		len = '0;
		for (int i = 0; i < MW; i++) begin
			if (orv[i]) begin
				len = LW'(i + 1);
			end
		end
	end

	logic          v_s4;
	logic [MW-1:0] m_s4 [3];
	logic [2:0]    neg_s4;
	logic [LW-1:0] sh_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s4   <= m_s3;
			neg_s4 <= neg_s3;
			sh_s4  <= (len > LW'(NB)) ? LW'(len - LW'(NB)) : '0;
		end
	end

	// stage 5: shift into range
	logic                 v_s5;
	logic [2:0][NB-1:0]   m_s5;
	logic [2:0]           neg_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				m_s5[i] <= NB'(m_s4[i] >> sh_s4);
			end
			neg_s5 <= neg_s4;
		end
	end

	// stage 6: squares
	logic               v_s6;
	logic [2:0][NB-1:0] m_s6;
	logic [2:0]         neg_s6;
	logic [2*NB-1:0]    sq_s6 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= (2*NB)'(m_s5[i]) * (2*NB)'(m_s5[i]);
			end
			m_s6   <= m_s5;
			neg_s6 <= neg_s5;
		end
	end

	// stage 7: sum of squares
	logic                 v_s7;
	logic [2:0][NB-1:0]   m_s7;
	logic [2:0]           neg_s7;
	logic [SUM_WIDTH-1:0] sum_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s7 <= SUM_WIDTH'(sq_s6[0]) + SUM_WIDTH'(sq_s6[1]) + SUM_WIDTH'(sq_s6[2]);
			m_s7   <= m_s6;
			neg_s7 <= neg_s6;
		end
	end

	assign out_tag.valid = v_s7;
	assign out_tag.neg   = neg_s7;
	assign out_mag       = m_s7;
	assign out_sum       = sum_s7;
endmodule
`default_nettype wire

// ===== rtl/qsn_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module qsn_isqrt (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  adv,
	input  qsn_pkg::tag_t                         in_tag,
	input  logic [2:0][qsn_pkg::NORM_BITS-1:0]    in_mag,
	input  logic [qsn_pkg::SUM_WIDTH-1:0]         in_sum,
	output qsn_pkg::tag_t                         out_tag,
	output logic [2:0][qsn_pkg::NORM_BITS-1:0]    out_mag,
	output logic [qsn_pkg::ROOT_WIDTH-1:0]        out_root
);
	import qsn_pkg::*;

	localparam int RW  = ROOT_WIDTH;
	localparam int SW  = SUM_WIDTH;
	localparam int NB  = NORM_BITS;
	localparam int RMW = RW + 2;

	tag_t               tag_s  [RW];
	logic [2:0][NB-1:0] mag_s  [RW];
	logic [SW-1:0]      sum_s  [RW];
	logic [RMW-1:0]     rem_s  [RW];
	logic [RW-1:0]      root_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_step
		tag_t               t_in;
		logic [2:0][NB-1:0] m_in;
		logic [SW-1:0]      s_in;
		logic [RMW-1:0]     rem_in;
		logic [RW-1:0]      root_in;
		logic [RMW+1:0]     rem_sh;
		logic [RMW+1:0]     trial;
		logic               take;

		if (k == 0) begin : g_first
			assign t_in    = in_tag;
			assign m_in    = in_mag;
			assign s_in    = in_sum;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign t_in    = tag_s[k-1];
			assign m_in    = mag_s[k-1];
			assign s_in    = sum_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		// bring down the next two bits and try root*4+1
		assign rem_sh = {rem_in, s_in[SW-1-2*k -: 2]};
		assign trial  = (RMW+2)'({root_in, 2'b01});
		assign take   = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= '0;
			end else if (adv) begin
				tag_s[k] <= t_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				mag_s[k]  <= m_in;
				sum_s[k]  <= s_in;
				rem_s[k]  <= take ? RMW'(rem_sh - trial) : RMW'(rem_sh);
				root_s[k] <= {root_in[RW-2:0], take};
			end
		end
	end

	assign out_tag  = tag_s[RW-1];
	assign out_mag  = mag_s[RW-1];
	assign out_root = root_s[RW-1];
endmodule
`default_nettype wire

// ===== rtl/qsn_div.sv =====
// Pipelined rounded division of the three magnitudes by the length, then saturation.
`default_nettype none
module qsn_div #(
	parameter int NW = qsn_pkg::NORMAL_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  adv,
	input  qsn_pkg::tag_t                         in_tag,
	input  logic [2:0][qsn_pkg::NORM_BITS-1:0]    in_mag,
	input  logic [qsn_pkg::ROOT_WIDTH-1:0]        in_root,
	output logic                                  out_valid,
	output logic signed [NW-1:0]                  normal_x,
	output logic signed [NW-1:0]                  normal_y,
	output logic signed [NW-1:0]                  normal_z,
	output logic                                  degenerate
);
	import qsn_pkg::*;

	localparam int RW = ROOT_WIDTH;
	localparam int NB = NORM_BITS;
	localparam int XW = NB + NW;

	// stage index 0 forms the rounded dividend, 1..NW take one quotient bit each
	tag_t               tag_s  [NW+1];
	logic [RW-1:0]      root_s [NW+1];
	logic [2:0][RW-1:0] rem_s  [NW+1];
	logic [2:0][NW-1:0] low_s  [NW+1];
	logic [2:0][NW-1:0] quo_s  [NW+1];

	logic [XW-1:0] num [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[i] = XW'({in_mag[i], {(NW-1){1'b0}}}) + XW'(in_root >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s[0] <= '0;
		end else if (adv) begin
			tag_s[0] <= in_tag;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			root_s[0] <= in_root;
			for (int i = 0; i < 3; i++) begin
				// the quotient fits NW bits, so the upper part is already below the root
				rem_s[0][i] <= RW'(num[i][XW-1:NW]);
				low_s[0][i] <= num[i][NW-1:0];
				quo_s[0][i] <= '0;
			end
		end
	end

	for (genvar k = 1; k <= NW; k++) begin : g_step
		logic [RW:0] sh   [3];
		logic [2:0]  take;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				sh[i]   = {rem_s[k-1][i], low_s[k-1][i][NW-1]};
				take[i] = sh[i] >= (RW+1)'(root_s[k-1]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= '0;
			end else if (adv) begin
				tag_s[k] <= tag_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				root_s[k] <= root_s[k-1];
				for (int i = 0; i < 3; i++) begin
					rem_s[k][i] <= take[i] ? RW'(sh[i] - (RW+1)'(root_s[k-1])) : RW'(sh[i]);
					low_s[k][i] <= {low_s[k-1][i][NW-2:0], 1'b0};
					quo_s[k][i] <= {quo_s[k-1][i][NW-2:0], take[i]};
				end
			end
		end
	end

	// output stage: saturate, apply sign, zero out a degenerate item
	localparam logic [NW-1:0] QMAX = {1'b0, {(NW-1){1'b1}}};

	logic [NW-1:0] sat [3];
	logic          deg;

	assign deg = (root_s[NW] == '0);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sat[i] = (quo_s[NW][i] > QMAX) ? QMAX : quo_s[NW][i];
		end
	end

	logic                 v_so;
	logic signed [NW-1:0] nrm_so [3];
	logic                 deg_so;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_so <= 1'b0;
		end else if (adv) begin
			v_so <= tag_s[NW].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_so <= deg;
			for (int i = 0; i < 3; i++) begin
				if (deg) begin
					nrm_so[i] <= '0;
				end else if (tag_s[NW].neg[i]) begin
					nrm_so[i] <= NW'(-sat[i]);
				end else begin
					nrm_so[i] <= sat[i];
				end
			end
		end
	end

	assign out_valid  = v_so;
	assign normal_x   = nrm_so[0];
	assign normal_y   = nrm_so[1];
	assign normal_z   = nrm_so[2];
	assign degenerate = deg_so;
endmodule
`default_nettype wire

// ===== tb/sv/qsn_tb_if.sv =====
// Result record type used by the testbench scoreboard.
`default_nettype none
package qsn_tb_types;
	timeunit 1ns;
	timeprecision 1ps;
	typedef struct {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic               degen;
	} normal_t;
endpackage
`default_nettype wire

// ===== tb/sv/tb_quadric_surface_normal.sv =====
// Testbench of the quadric surface normal unit: directed table, random items, scoreboard.
`default_nettype none
module tb_quadric_surface_normal;
	timeunit 1ns;
	timeprecision 1ps;
	import qsn_pkg::*;
	import qsn_tb_types::*;

	localparam int CW = 32;
	localparam int NW = 16;
	localparam int N_RANDOM = 850;
	localparam int LATENCY = NW + 40;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		op_t                  op;
		logic signed [CW-1:0] cx, cy, cz, slope, px, py, pz;
		logic                 has_fixed;
		normal_t              fixed;
	} hit_t;

	logic clk;
	logic arst_n;
	qsn_in_if  #(.CW(CW)) req ();
	qsn_out_if #(.NW(NW)) rsp ();

	quadric_surface_normal #(.COORD_WIDTH(CW), .NORMAL_WIDTH(NW)) uut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp)
	);

	normal_t pending_normals[$];
	hit_t    hit_table[$];
	int      fail_count = 0;
	longint  cycle_count = 0;
	bit      quiet_phase = 0;
	bit      hold_off = 0;
	bit      feeding_done = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic logic [63:0] bit_len(logic [127:0] v);
		logic [63:0] n;
		n = 0;
		for (int i = 0; i < 128; i++)
			if (v[i]) n = 64'(i + 1);
		return n;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] s);
		logic [63:0] root, b;
		root = 0;
		b = 64'd1 << 62;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= root + b) begin
				s = s - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic normal_t predict_normal(hit_t h);
		normal_t res;
		logic [127:0] mag[3];
		logic neg[3];
		logic signed [CW:0] d[3];
		logic [63:0] slope_mag, len, sum, root, q;
		logic slope_neg;
		res = '{nx: 0, ny: 0, nz: 0, degen: 1};
		if (h.op == OP_NONE) return res;
		d[0] = {h.px[CW-1], h.px} - {h.cx[CW-1], h.cx};
		d[1] = {h.py[CW-1], h.py} - {h.cy[CW-1], h.cy};
		d[2] = {h.pz[CW-1], h.pz} - {h.cz[CW-1], h.cz};
		for (int i = 0; i < 3; i++) begin
			neg[i] = d[i][CW];
			mag[i] = neg[i] ? 128'(-d[i]) : 128'(d[i]);
			mag[i] = mag[i] & ((128'd1 << (CW + 1)) - 1);
		end
		if (h.op == OP_CYLINDER) begin
			mag[2] = 0;
			neg[2] = 0;
		end else if (h.op == OP_CONE) begin
			slope_neg = h.slope[CW-1];
			slope_mag = slope_neg ? 64'(-65'(h.slope)) : 64'(h.slope);
			mag[2] = (128'(slope_mag) * mag[2]) >> FRAC_BITS;
			neg[2] = (slope_neg == neg[2]) && (mag[2] != 0);
		end
		len = 0;
		for (int i = 0; i < 3; i++)
			if (bit_len(mag[i]) > len) len = bit_len(mag[i]);
		if (len == 0) return res;
		if (len > NORM_BITS)
			for (int i = 0; i < 3; i++) mag[i] = mag[i] >> (len - NORM_BITS);
		sum = 0;
		for (int i = 0; i < 3; i++) sum = sum + mag[i][63:0] * mag[i][63:0];
		root = int_sqrt(sum);
		if (root == 0) return res;
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i][63:0] << (NW - 1)) + (root >> 1)) / root;
			if (q > (64'd1 << (NW - 1)) - 1) q = (64'd1 << (NW - 1)) - 1;
			q = neg[i] ? -q : q;
			if (i == 0) res.nx = q[NW-1:0];
			else if (i == 1) res.ny = q[NW-1:0];
			else res.nz = q[NW-1:0];
		end
		res.degen = 0;
		return res;
	endfunction

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 255) - 128;
			1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, {(CW-1){1'b0}}} ^ $urandom_range(0, 3);
			2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic hit_t random_hit();
		hit_t h;
		h.op = op_t'($urandom_range(0, 3));
		h.cx = rand_coord(); h.cy = rand_coord(); h.cz = rand_coord();
		h.slope = rand_coord();
		// keep point near the center often, so small vectors appear
		if ($urandom_range(0, 2) == 0) begin
			h.px = h.cx + $urandom_range(0, 64) - 32;
			h.py = h.cy + $urandom_range(0, 64) - 32;
			h.pz = h.cz + $urandom_range(0, 64) - 32;
		end else begin
			h.px = rand_coord(); h.py = rand_coord(); h.pz = rand_coord();
		end
		h.has_fixed = 0;
		h.fixed = '{nx: 0, ny: 0, nz: 0, degen: 0};
		return h;
	endfunction

	function automatic hit_t mk(op_t op, logic [CW-1:0] cx, cy, cz, slope, px, py, pz,
			bit fixed, logic signed [15:0] nx, ny, nz, logic dg);
		hit_t h;
		h.op = op; h.cx = cx; h.cy = cy; h.cz = cz; h.slope = slope;
		h.px = px; h.py = py; h.pz = pz;
		h.has_fixed = fixed;
		h.fixed = '{nx: nx, ny: ny, nz: nz, degen: dg};
		return h;
	endfunction

	task automatic build_directed();
		localparam logic [CW-1:0] MX = 32'h7fff_ffff;
		localparam logic [CW-1:0] MN = 32'h8000_0000;
		localparam logic [CW-1:0] ONE = 32'h0001_0000;
		hit_table.push_back(mk(OP_NONE, 0, 0, 0, 0, ONE, 0, 0, 1, 0, 0, 0, 1));
		hit_table.push_back(mk(OP_SPHERE, 5, 6, 7, 0, 5, 6, 7, 1, 0, 0, 0, 1));
		hit_table.push_back(mk(OP_CYLINDER, 5, 6, 7, 0, 5, 6, 99, 1, 0, 0, 0, 1));
		hit_table.push_back(mk(OP_CONE, 0, 0, 0, 0, 0, 0, ONE, 1, 0, 0, 0, 1));
		hit_table.push_back(mk(OP_CONE, 0, 0, 0, 1, 0, 0, 1, 1, 0, 0, 0, 1));
		hit_table.push_back(mk(OP_SPHERE, 0, 0, 0, 0, ONE, 0, 0, 1, 16'sd32767, 0, 0, 0));
		hit_table.push_back(mk(OP_SPHERE, 0, 0, 0, 0, 0, -ONE, 0, 1, 0, -16'sd32767, 0, 0));
		hit_table.push_back(mk(OP_SPHERE, 0, 0, 0, 0, 0, 0, ONE, 1, 0, 0, 16'sd32767, 0));
		hit_table.push_back(mk(OP_CYLINDER, 0, 0, 0, 0, 0, 1, MX, 1, 0, 16'sd32767, 0, 0));
		hit_table.push_back(mk(OP_SPHERE, MN, MN, MN, 0, MX, MX, MX, 0, 0, 0, 0, 0));
		hit_table.push_back(mk(OP_SPHERE, MX, MX, MX, 0, MN, MN, MN, 0, 0, 0, 0, 0));
		hit_table.push_back(mk(OP_SPHERE, MN, 0, 0, 0, MX, 0, 0, 0, 0, 0, 0, 0));
		hit_table.push_back(mk(OP_CYLINDER, MN, MX, MN, MX, MX, MN, MX, 0, 0, 0, 0, 0));
		hit_table.push_back(mk(OP_CONE, 0, 0, MN, MX, 0, 0, MX, 0, 0, 0, 0, 0));
		hit_table.push_back(mk(OP_CONE, 0, 0, MN, MN, 1, 1, MX, 0, 0, 0, 0, 0));
		hit_table.push_back(mk(OP_CONE, ONE, 0, 0, -ONE, 0, ONE, ONE, 0, 0, 0, 0, 0));
		hit_table.push_back(mk(OP_CONE, 0, 0, ONE, ONE, ONE, 0, 0, 0, 0, 0, 0, 0));
		hit_table.push_back(mk(OP_SPHERE, 0, 0, 0, 0, 3, 4, 0, 0, 0, 0, 0, 0));
		hit_table.push_back(mk(OP_SPHERE, 0, 0, 0, 0, -1, -1, -1, 0, 0, 0, 0, 0));
		hit_table.push_back(mk(OP_NONE, MX, MN, MX, MN, MN, MX, MN, 1, 0, 0, 0, 1));
	endtask

	// Sender
	initial begin
		hit_t h;
		arst_n = 0;
		req.valid = 0; req.op = OP_SPHERE;
		req.center_x = 0; req.center_y = 0; req.center_z = 0; req.cone_slope = 0;
		req.point_x = 0; req.point_y = 0; req.point_z = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		build_directed();
		for (int i = 0; i < N_RANDOM; i++) hit_table.push_back(random_hit());
		for (int i = 0; i < hit_table.size(); i++) begin
			h = hit_table[i];
			quiet_phase = (i >= 300 && i < 450);
			while (!quiet_phase && $urandom_range(0, 99) < 10) begin
				req.valid <= 0;
				@(posedge clk);
			end
			req.valid <= 1; req.op <= h.op;
			req.center_x <= h.cx; req.center_y <= h.cy; req.center_z <= h.cz;
			req.cone_slope <= h.slope;
			req.point_x <= h.px; req.point_y <= h.py; req.point_z <= h.pz;
			do @(posedge clk); while (!req.ready);
			pending_normals.push_back(h.has_fixed ? h.fixed : predict_normal(h));
		end
		req.valid <= 0;
		feeding_done = 1;
	end

	// Receiver: random stalls plus one long hold-off
	initial begin
		int rx_cycles;
		rsp.ready = 0;
		rx_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			rx_cycles++;
			hold_off = (rx_cycles >= 200 && rx_cycles < 500);
			rsp.ready <= hold_off ? 1'b0 : (quiet_phase ? 1'b1 : ($urandom_range(0, 99) >= 10));
		end
	end

	// Checker
	always @(posedge clk) begin
		normal_t exp_n;
		cycle_count <= cycle_count + 1;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_normals.size() == 0) begin
				$error("result with no expectation waiting");
				fail_count++;
			end else begin
				exp_n = pending_normals.pop_front();
				if (rsp.normal_x !== exp_n.nx) begin
					$error("normal_x expected %0d actual %0d", exp_n.nx, rsp.normal_x);
					fail_count++;
				end
				if (rsp.normal_y !== exp_n.ny) begin
					$error("normal_y expected %0d actual %0d", exp_n.ny, rsp.normal_y);
					fail_count++;
				end
				if (rsp.normal_z !== exp_n.nz) begin
					$error("normal_z expected %0d actual %0d", exp_n.nz, rsp.normal_z);
					fail_count++;
				end
				if (rsp.degenerate !== exp_n.degen) begin
					$error("degenerate expected %0d actual %0d", exp_n.degen, rsp.degenerate);
					fail_count++;
				end
			end
		end
	end

	initial begin
		@(posedge clk);
		while (!(feeding_done && pending_normals.size() == 0) && cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("quadric_surface_normal verification failed");
			$finish;
		end else begin
			repeat (2 * LATENCY) @(posedge clk);
			if (fail_count == 0)
				$display("quadric_surface_normal verification clean");
			else
				$display("quadric_surface_normal verification failed");
			$finish;
		end
	end
endmodule
`default_nettype wire
